>>> sv/ssr_pkg.sv
// Shared types and constants for the streaming find-and-replace block
`timescale 1ns / 1ps

package ssr_pkg;

  // size limits of the pattern and the replacement
  localparam int MAX_PATTERN     = 16;
  localparam int MAX_REPLACEMENT = 16;

  // window cells and index widths
  localparam int NUM_CELLS  = 16;
  localparam int CELL_IDX_W = 4;
  localparam int FILL_W     = 5;
  localparam int LEN_W      = 5;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // register indexes of the write port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO  = 3'd0,
    REG_PAT_HI  = 3'd1,
    REG_PAT_LEN = 3'd2,
    REG_REP_LO  = 3'd3,
    REG_REP_HI  = 3'd4,
    REG_REP_LEN = 3'd5
  } reg_index_t;

  // sequencer phases
  typedef enum logic [1:0] {
    P_IDLE,
    P_CHECK,
    P_REPL,
    P_FLUSH
  } phase_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
  } result_t;

  // control shared by every window cell
  typedef struct packed {
    logic load;
    logic shift;
    logic cmp_shift;
  } cell_ctrl_t;

endpackage

>>> sv/ssr_text_if.sv
// Text input channel: valid/ready with one text byte per item
`timescale 1ns / 1ps

interface ssr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> sv/ssr_result_if.sv
// Result output channel: valid/ready with at most one rewritten byte per item, flagged by has_byte
`timescale 1ns / 1ps

interface ssr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output out_byte, output has_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last, output ready);
endinterface

>>> sv/ssr_cell.sv
// One window cell: holds a byte, takes an insert or its neighbor's byte, compares to pattern
`timescale 1ns / 1ps

module ssr_cell (
  input  logic              clk,
  input  ssr_pkg::cell_ctrl_t ctrl,
  input  logic              ins_sel,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        nbr_cur,
  input  logic [7:0]        pat_byte,
  output logic [7:0]        cur,
  output logic              eq
);
  import ssr_pkg::*;

  logic [7:0] held;

  // byte as seen this cycle, with a new text byte landing here
  assign cur = ins_sel ? in_byte : held;

  // compare own byte, or the neighbor's when looking one shift ahead
  assign eq = ((ctrl.cmp_shift ? nbr_cur : cur) == pat_byte);

  // hold, or move the neighbor's byte down
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      held <= ctrl.shift ? nbr_cur : cur;
    end
  end

endmodule

>>> sv/ssr_out_buf.sv
// Two-entry result buffer between the sequencer and the result channel
`timescale 1ns / 1ps

module ssr_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ssr_pkg::result_t push_data,
  output logic             space,
  ssr_result_if.source     result
);
  import ssr_pkg::*;

  result_t    head;
  result_t    tail;
  logic [1:0] count;
  logic       pop;

  assign pop   = result.valid && result.ready;
  assign space = (count != 2'd2);

  assign result.valid    = (count != 2'd0);
  assign result.out_byte = head.out_byte;
  assign result.has_byte = head.has_byte;
  assign result.last     = head.last;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) head <= push_data;
      end
      2'd1: begin
        if (push && pop) head <= push_data;
        else if (push) tail <= push_data;
      end
      default: begin
        if (pop) head <= tail;
      end
    endcase
  end

endmodule

>>> sv/stream_substring_replace.sv
// Top level of the streaming find-and-replace block
//
//  channel   dir  handshake     payload
//  text      in   valid/ready   text_byte[7:0], end_of_text
//  result    out  valid/ready   out_byte[7:0], has_byte, last
//  wr_*      in   wr_en only    wr_index[2:0], wr_data[63:0]
//
// Text is taken only in the idle phase; an item holds off further input while
// the check, replacement and flush phases emit the results it causes. The
// window-cell row emits at most one result per cycle, while the result buffer
// has space. Synchronous active-high reset empties the window and result
// buffer and restores register defaults. Result stalls back up through the
// two-entry buffer.
`timescale 1ns / 1ps

module stream_substring_replace (
  input  logic                          clk,
  input  logic                          rst,
  ssr_text_if.sink                      text,
  ssr_result_if.source                  result,
  input  logic                          wr_en,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ssr_pkg::CFG_W-1:0]     wr_data
);
  import ssr_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] pat_lo;
  logic [CFG_W-1:0] pat_hi;
  logic [LEN_W-1:0] pat_len;
  logic [CFG_W-1:0] rep_lo;
  logic [CFG_W-1:0] rep_hi;
  logic [LEN_W-1:0] rep_len;

  // sequencer state
  phase_t                phase;
  phase_t                phase_next;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_next;
  logic                  endf;
  logic                  endf_next;
  logic [CELL_IDX_W-1:0] rcnt;
  logic [CELL_IDX_W-1:0] rcnt_next;

  logic [LEN_W-1:0]      plen_eff;
  logic [LEN_W-1:0]      rlen_eff;
  logic                  space;
  logic                  in_acc;
  logic                  go;
  logic                  ins;
  logic                  endv;
  logic [FILL_W-1:0]     fv;
  logic [FILL_W-1:0]     fv_dec;
  logic                  surplus;
  logic                  surplus_end;
  logic                  hit;
  logic                  pop_now;
  logic                  repl_done;
  logic                  match;
  logic                  shift;
  logic                  emit;
  result_t               emit_res;
  logic [CELL_IDX_W-1:0] rep_idx;
  logic [7:0]            rep_byte;
  logic [2*CFG_W-1:0]    pat_all;
  logic [2*CFG_W-1:0]    rep_all;
  cell_ctrl_t            ctrl;

  logic [7:0]            cur [NUM_CELLS];
  logic [7:0]            nbr [NUM_CELLS];
  logic                  eq  [NUM_CELLS];
  logic                  ins_sel [NUM_CELLS];

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo  <= '0;
      pat_hi  <= '0;
      pat_len <= LEN_W'(1);
      rep_lo  <= '0;
      rep_hi  <= '0;
      rep_len <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PAT_LO:  pat_lo  <= wr_data;
        REG_PAT_HI:  pat_hi  <= wr_data;
        REG_PAT_LEN: pat_len <= wr_data[LEN_W-1:0];
        REG_REP_LO:  rep_lo  <= wr_data;
        REG_REP_HI:  rep_hi  <= wr_data;
        REG_REP_LEN: rep_len <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp lengths to the supported range
  always_comb begin
    if (pat_len == '0) plen_eff = LEN_W'(1);
    else if (pat_len > LEN_W'(MAX_PATTERN)) plen_eff = LEN_W'(MAX_PATTERN);
    else plen_eff = pat_len;
    if (rep_len > LEN_W'(MAX_REPLACEMENT)) rlen_eff = LEN_W'(MAX_REPLACEMENT);
    else rlen_eff = rep_len;
  end

  assign pat_all = {pat_hi, pat_lo};
  assign rep_all = {rep_hi, rep_lo};

  // handshake and step enable
  assign text.ready = (phase == P_IDLE) && space;
  assign in_acc     = text.valid && text.ready;
  assign go         = (phase == P_IDLE) ? in_acc : space;
  assign ins        = (phase == P_IDLE);
  assign endv       = ins ? text.end_of_text : endf;
  assign fv         = ins ? (fill + FILL_W'(1)) : fill;
  assign fv_dec     = fv - FILL_W'(1);

  // window cell row
  assign ctrl.load      = go;
  assign ctrl.shift     = shift;
  assign ctrl.cmp_shift = surplus;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    assign ins_sel[k] = ins && (fill[CELL_IDX_W-1:0] == CELL_IDX_W'(k));
    if (k == NUM_CELLS - 1) begin : g_end
      assign nbr[k] = 8'd0;
    end else begin : g_mid
      assign nbr[k] = cur[k+1];
    end
    ssr_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .ins_sel  (ins_sel[k]),
      .in_byte  (text.text_byte),
      .nbr_cur  (nbr[k]),
      .pat_byte (pat_all[8*k +: 8]),
      .cur      (cur[k]),
      .eq       (eq[k])
    );
  end

  // full match over the cells in use
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < NUM_CELLS; k++) begin
      if ((LEN_W'(k) < plen_eff) && !eq[k]) match = 1'b0;
    end
  end

  // replacement byte select
  assign rep_idx  = (phase == P_REPL) ? rcnt : '0;
  assign rep_byte = rep_all[{rep_idx, 3'b000} +: 8];

  // decision flags
  assign surplus     = (fv > plen_eff);
  assign surplus_end = surplus && endv && (rlen_eff == '0) && (fv_dec == plen_eff) && match;
  assign hit         = !surplus && (fv == plen_eff) && match;
  assign pop_now     = !surplus && !hit && ((fv == plen_eff) || endv);
  assign repl_done   = ({1'b0, rcnt} + LEN_W'(1)) == rlen_eff;

  // next phase
  always_comb begin
    phase_next = phase;
    if (go) begin
      unique case (phase) inside
        P_IDLE, P_CHECK: begin
          if (surplus) phase_next = surplus_end ? P_IDLE : P_CHECK;
          else if (hit) phase_next = (rlen_eff > LEN_W'(1)) ? P_REPL : P_IDLE;
          else if (pop_now) phase_next = (endv && (fv != FILL_W'(1))) ? P_FLUSH : P_IDLE;
          else phase_next = P_IDLE;
        end
        P_REPL: begin
          if (repl_done) phase_next = P_IDLE;
        end
        P_FLUSH: begin
          if (fill == FILL_W'(1)) phase_next = P_IDLE;
        end
        default: phase_next = P_IDLE;
      endcase
    end
  end

  // emitted result and datapath updates
  always_comb begin
    fill_next = fill;
    endf_next = endf;
    rcnt_next = rcnt;
    shift     = 1'b0;
    emit      = 1'b0;
    emit_res  = '{out_byte: cur[0], has_byte: 1'b1, last: 1'b0};
    if (go) begin
      unique case (phase) inside
        P_IDLE, P_CHECK: begin
          endf_next = endv;
          if (surplus) begin
            emit          = 1'b1;
            shift         = 1'b1;
            fill_next     = surplus_end ? '0 : fv_dec;
            emit_res.last = surplus_end;
          end else if (hit) begin
            fill_next = '0;
            rcnt_next = CELL_IDX_W'(1);
            if (rlen_eff == '0) begin
              emit     = endv;
              emit_res = '{out_byte: 8'd0, has_byte: 1'b0, last: 1'b1};
            end else begin
              emit     = 1'b1;
              emit_res = '{out_byte: rep_byte, has_byte: 1'b1,
                           last: endv && (rlen_eff == LEN_W'(1))};
            end
          end else if (pop_now) begin
            emit          = 1'b1;
            shift         = 1'b1;
            fill_next     = fv_dec;
            emit_res.last = endv && (fv == FILL_W'(1));
          end else begin
            fill_next = fv;
          end
        end
        P_REPL: begin
          emit      = 1'b1;
          emit_res  = '{out_byte: rep_byte, has_byte: 1'b1, last: endf && repl_done};
          rcnt_next = rcnt + CELL_IDX_W'(1);
        end
        P_FLUSH: begin
          emit          = 1'b1;
          shift         = 1'b1;
          fill_next     = fill - FILL_W'(1);
          emit_res.last = (fill == FILL_W'(1));
        end
        default: ;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      fill  <= '0;
      endf  <= 1'b0;
      rcnt  <= '0;
    end else begin
      phase <= phase_next;
      fill  <= fill_next;
      endf  <= endf_next;
      rcnt  <= rcnt_next;
    end
  end

  // result buffer
  ssr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (emit_res),
    .space     (space),
    .result    (result)
  );

  // the window never holds more bytes than its cells
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(NUM_CELLS - 1))
    else $error("window fill out of range");

  // no result is pushed into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    emit |-> space)
    else $error("result pushed without buffer space");

  // a replacement burst runs on an empty window and stays within its length
  a_repl_state: assert property (@(posedge clk) disable iff (rst)
    (phase == P_REPL) |-> ((fill == '0) && ({1'b0, rcnt} < rlen_eff)))
    else $error("replacement burst out of step");

  // a final result returns the sequencer to accepting text
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && go && emit_res.last) |=> (phase == P_IDLE) && (fill == '0))
    else $error("sequencer busy after final result");

endmodule
